[rtl/mpq_pkg.sv]
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes of the active/expired multilevel priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int PROC_ID_W = 8;
  localparam int PRIO_W    = 3;
  localparam int GLEVEL_W  = 2;
  localparam int NEWPRIO_W = 2;

  typedef enum logic {
    FUNC_ADD  = 1'b0,
    FUNC_TAKE = 1'b1
  } mpq_func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_RDATA,
    ST_DONE
  } mpq_state_t;

  // sequencer controls toward the datapath
  typedef struct packed {
    logic in_ready;
    logic push;
    logic pop;
    logic step_down;
    logic swap;
    logic load_out;
  } mpq_ctrl_t;

endpackage

[rtl/mpq_if.sv]
// ----------------------------------------------------------------------------
// mpq_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpq_in_if;
  import mpq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [PROC_ID_W-1:0] proc_id;
  logic signed [PRIO_W-1:0] dyn_prio;
  logic [PRIO_W-1:0]    static_prio;

  modport source (output valid, func, proc_id, dyn_prio, static_prio, input ready);
  modport sink   (input valid, func, proc_id, dyn_prio, static_prio, output ready);
endinterface

interface mpq_out_if;
  import mpq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 grant_valid;
  logic [PROC_ID_W-1:0] grant_id;
  logic [GLEVEL_W-1:0]  grant_level;
  logic                 accepted;
  logic [NEWPRIO_W-1:0] new_prio;
  logic                 swapped;

  modport source (output valid, grant_valid, grant_id, grant_level, accepted, new_prio,
                  swapped, input ready);
  modport sink   (input valid, grant_valid, grant_id, grant_level, accepted, new_prio,
                  swapped, output ready);
endinterface

[rtl/mpq_cmp.sv]
// ----------------------------------------------------------------------------
// mpq_cmp
// Shared queue-count compare: full check on add, non-empty check on scan.
// ----------------------------------------------------------------------------
module mpq_cmp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic [CW-1:0] count,
  input  logic          sel_full,
  output logic          hit
);

  always_comb begin
    if (sel_full) begin
      hit = (count >= CW'(QUEUE_DEPTH));
    end else begin
      hit = (count != '0);
    end
  end

endmodule

[rtl/mpq_slot_ram.sv]
// ----------------------------------------------------------------------------
// mpq_slot_ram
// Process id storage for all queues, one write and one registered read port.
// ----------------------------------------------------------------------------
module mpq_slot_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/multilevel_priority_active_expired_queue_unit.sv]
// ----------------------------------------------------------------------------
// multilevel_priority_active_expired_queue_unit
// Active/expired ready-queue scheduler with one FIFO per bank and level.
// ----------------------------------------------------------------------------
// One request word is handled at a time. An add steps through accept, one
// full check on the shared count comparator with the slot write, and result load.
// A take walks the active bank from the top level down, one level per cycle
// on that same comparator, and after an empty bank swaps and walks the other
// one; it visits from 1 to 2*LEVELS levels, and all 2*LEVELS when nothing
// is found. The slot memory has a registered read, so a grant passes through
// a read-data state before the result load.
// A finished result waits in the output register while the next word is
// accepted; it is only held back at load time if still not taken.
module multilevel_priority_active_expired_queue_unit
  import mpq_pkg::*;
#(
  parameter int LEVELS      = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  mpq_in_if.sink  in_ch,
  mpq_out_if.source out_ch
);

  localparam int NQ    = 2 * LEVELS;
  localparam int QW    = $clog2(NQ);
  localparam int LW    = $clog2(LEVELS);
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS = NQ * QUEUE_DEPTH;
  localparam int AW    = $clog2(SLOTS);

  mpq_state_t state_r, state_nxt;
  mpq_ctrl_t  ctrl;

  logic            active_bank_r;
  logic [PW-1:0]   head_r [NQ];
  logic [PW-1:0]   tail_r [NQ];
  logic [CW-1:0]   cnt_r  [NQ];

  logic            func_r;
  logic [ID_BITS-1:0] id_r;
  logic            add_bank_r;
  logic [LW-1:0]   tgt_lvl_r;
  logic            bank_r;
  logic [LW-1:0]   lvl_r;
  logic            res_gv_r;
  logic [PROC_ID_W-1:0] res_gid_r;
  logic            res_acc_r;
  logic [NEWPRIO_W-1:0] res_np_r;
  logic            res_sw_r;

  logic            out_valid_r;
  logic            o_gv_r;
  logic [PROC_ID_W-1:0] o_gid_r;
  logic [GLEVEL_W-1:0]  o_glev_r;
  logic            o_acc_r;
  logic [NEWPRIO_W-1:0] o_np_r;
  logic            o_sw_r;

  logic            q_bank;
  logic [LW-1:0]   q_lvl;
  logic [QW-1:0]   q_sel;
  logic [CW-1:0]   cnt_sel;
  logic            cmp_hit;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;
  logic [ID_BITS-1:0] rdata;
  logic [ID_BITS+PROC_ID_W-1:0] id_in_ext;
  logic [ID_BITS+PROC_ID_W-1:0] id_out_ext;
  logic [LW+GLEVEL_W-1:0] glev_ext;
  logic [4:0]      raw_lvl;
  logic [4:0]      sat_lvl;
  logic            in_fire;

  assign in_fire = in_ch.valid && ctrl.in_ready;

  // add target level with saturation
  always_comb begin
    if (in_ch.dyn_prio[PRIO_W-1]) begin
      raw_lvl = (in_ch.static_prio == '0) ? 5'd0 : 5'(in_ch.static_prio) - 5'd1;
    end else begin
      raw_lvl = 5'(in_ch.dyn_prio[PRIO_W-2:0]);
    end
    sat_lvl = (raw_lvl > 5'(LEVELS - 1)) ? 5'(LEVELS - 1) : raw_lvl;
  end

  assign q_bank  = (state_r == ST_ADD) ? add_bank_r : bank_r;
  assign q_lvl   = (state_r == ST_ADD) ? tgt_lvl_r : lvl_r;
  assign q_sel   = (q_bank ? QW'(LEVELS) : QW'(0)) + QW'(q_lvl);
  assign cnt_sel = cnt_r[q_sel];
  assign waddr   = AW'(q_sel) * AW'(QUEUE_DEPTH) + AW'(tail_r[q_sel]);
  assign raddr   = AW'(q_sel) * AW'(QUEUE_DEPTH) + AW'(head_r[q_sel]);

  assign id_in_ext  = {{ID_BITS{1'b0}}, in_ch.proc_id};
  assign id_out_ext = {{PROC_ID_W{1'b0}}, rdata};
  assign glev_ext   = {{GLEVEL_W{1'b0}}, lvl_r};

  mpq_cmp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_cmp (
    .count    (cnt_sel),
    .sel_full (state_r == ST_ADD),
    .hit      (cmp_hit)
  );

  mpq_slot_ram #(
    .DEPTH(SLOTS),
    .WIDTH(ID_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.push),
    .waddr (waddr),
    .wdata (id_r),
    .re    (ctrl.pop),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (in_ch.func == FUNC_TAKE) ? ST_SCAN : ST_ADD;
        end
      end
      ST_ADD: state_nxt = ST_DONE;
      ST_SCAN: begin
        if (cmp_hit) begin
          state_nxt = ST_RDATA;
        end else if (lvl_r == '0 && res_sw_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RDATA: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    unique case (state_r)
      ST_IDLE:  ctrl.in_ready = 1'b1;
      ST_ADD:   ctrl.push = !cmp_hit;
      ST_SCAN: begin
        ctrl.pop       = cmp_hit;
        ctrl.step_down = !cmp_hit && (lvl_r != '0);
        ctrl.swap      = !cmp_hit && (lvl_r == '0) && !res_sw_r;
      end
      ST_RDATA: ctrl = '0;
      ST_DONE:  ctrl.load_out = !out_valid_r || out_ch.ready;
      default:  ctrl = '0;
    endcase
  end

  assign in_ch.ready = ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      active_bank_r <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < NQ; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (ctrl.push) begin
        tail_r[q_sel] <= (tail_r[q_sel] == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_r[q_sel] + 1'b1;
        cnt_r[q_sel]  <= cnt_r[q_sel] + 1'b1;
      end
      if (ctrl.pop) begin
        head_r[q_sel] <= (head_r[q_sel] == PW'(QUEUE_DEPTH - 1)) ? '0 : head_r[q_sel] + 1'b1;
        cnt_r[q_sel]  <= cnt_r[q_sel] - 1'b1;
      end
      if (ctrl.swap) begin
        active_bank_r <= ~active_bank_r;
      end
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-word working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r     <= in_ch.func;
      id_r       <= id_in_ext[ID_BITS-1:0];
      add_bank_r <= in_ch.dyn_prio[PRIO_W-1] ? ~active_bank_r : active_bank_r;
      tgt_lvl_r  <= LW'(sat_lvl);
      bank_r     <= active_bank_r;
      lvl_r      <= LW'(LEVELS - 1);
      res_gv_r   <= 1'b0;
      res_gid_r  <= '0;
      res_acc_r  <= 1'b0;
      res_np_r   <= (in_ch.func == FUNC_ADD) ? sat_lvl[NEWPRIO_W-1:0] : '0;
      res_sw_r   <= 1'b0;
    end
    if (ctrl.push) begin
      res_acc_r <= 1'b1;
    end
    if (ctrl.step_down) begin
      lvl_r <= lvl_r - 1'b1;
    end
    if (ctrl.swap) begin
      bank_r   <= ~bank_r;
      lvl_r    <= LW'(LEVELS - 1);
      res_sw_r <= 1'b1;
    end
    if (ctrl.pop) begin
      res_gv_r <= 1'b1;
    end
    if (state_r == ST_RDATA) begin
      res_gid_r <= id_out_ext[PROC_ID_W-1:0];
    end
    if (ctrl.load_out) begin
      o_gv_r   <= res_gv_r;
      o_gid_r  <= res_gid_r;
      o_glev_r <= res_gv_r ? glev_ext[GLEVEL_W-1:0] : '0;
      o_acc_r  <= res_acc_r;
      o_np_r   <= (func_r == FUNC_ADD) ? res_np_r : '0;
      o_sw_r   <= res_sw_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.grant_valid = o_gv_r;
  assign out_ch.grant_id    = o_gid_r;
  assign out_ch.grant_level = o_glev_r;
  assign out_ch.accepted    = o_acc_r;
  assign out_ch.new_prio    = o_np_r;
  assign out_ch.swapped     = o_sw_r;

endmodule

[rtl/mpq_checker.sv]
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks of the queue unit, attached by bind.
// ----------------------------------------------------------------------------
module mpq_checker
  import mpq_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 grant_valid,
  input logic [PROC_ID_W-1:0] grant_id,
  input logic [GLEVEL_W-1:0]  grant_level,
  input logic                 accepted,
  input logic [NEWPRIO_W-1:0] new_prio,
  input logic                 swapped
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !grant_valid |-> grant_id == '0 && grant_level == '0)
    else $error("grant fields set without grant");

  a_add_no_take_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && accepted |-> !grant_valid && !swapped)
    else $error("add result carries take fields");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(grant_id) && $stable(new_prio))
    else $error("stalled result changed");

endmodule

bind multilevel_priority_active_expired_queue_unit mpq_checker u_mpq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .grant_valid (out_ch.grant_valid),
  .grant_id    (out_ch.grant_id),
  .grant_level (out_ch.grant_level),
  .accepted    (out_ch.accepted),
  .new_prio    (out_ch.new_prio),
  .swapped     (out_ch.swapped)
);
